// ----- rtl/flsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flsa_pkg
// Shared types and constants of the free-list slot allocator: field widths,
// operation and status codes, register indexes and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package flsa_pkg;

   // field widths
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 16;
   localparam int CAP_W      = 11;
   localparam int SLOT_IDX_W = 10;
   localparam int STATUS_W   = 3;
   localparam int FREE_W     = 11;
   localparam int FUNC_W     = 2;
   localparam int CSR_IDX_W  = 2;

   // register reset values
   localparam logic [ADDR_W-1:0] BASE_RESET = 32'd0;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd1;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 11'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_SIZE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_CAPACITY = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ACQUIRE    = 2'd0,
      FUNC_RELEASE    = 2'd1,
      FUNC_RESET_POOL = 2'd2,
      FUNC_NOP        = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BELOW    = 3'd2,
      ST_MISALIGN = 3'd3,
      ST_RANGE    = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // take the accepted item
      logic acq_read;    // read top of stack
      logic acq_mul;     // pick index, multiply by element size
      logic acq_commit;  // pop and stage the address
      logic set_empty;   // stage an empty report
      logic set_nop;     // stage a plain ok
      logic refill;      // refill the pool
      logic div_start;   // start the offset division
      logic rel_commit;  // check release and push
      logic emit;        // move staged result to the output register
   } flsa_cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     count_zero;
      logic     div_done;
      logic     out_free;
   } flsa_stat_type;

endpackage : flsa_pkg
`default_nettype wire

// ----- rtl/flsa_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flsa_divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per
// cycle. Done pulses for one cycle when quotient and remainder are final.
// ----------------------------------------------------------------------------
module flsa_divider
   import flsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ADDR_W-1:0] dividend,
   input  wire logic [SIZE_W-1:0] divisor,
   output logic                   done,
   output logic [ADDR_W-1:0]      quotient,
   output logic [SIZE_W-1:0]      remainder
);

   localparam int STEPS = ADDR_W;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [ADDR_W-1:0] quo_ff;
   logic [SIZE_W-1:0] rem_ff;
   logic [SIZE_W-1:0] dsr_ff;

   logic [SIZE_W:0]   shifted;
   logic [SIZE_W+1:0] diff;
   logic              fits;
   logic [SIZE_W-1:0] rem_in;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[ADDR_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = ~diff[SIZE_W+1];
      rem_in  = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
   end

   // sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            steps_ff <= STEP_W'(STEPS);
         end else if (busy_ff) begin
            steps_ff <= steps_ff - 1'b1;
            if (steps_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient and remainder shift
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[ADDR_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule : flsa_divider
`default_nettype wire

// ----- rtl/flsa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flsa_datapath
// Configuration registers, free-index stack memory with its count and
// low-water mark, address multiply, release checks, staged result and the
// output register.
// ----------------------------------------------------------------------------
module flsa_datapath
   import flsa_pkg::*;
#(
   parameter int POOL_DEPTH = 1024
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire flsa_cmd_type         cmd,
   output flsa_stat_type             stat,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [ADDR_W-1:0]    req_freed_address,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_slot_address,
   output logic [SLOT_IDX_W-1:0]     rsp_slot_index,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [FREE_W-1:0]         rsp_free_slots,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data
);

   localparam int IDX_W     = $clog2(POOL_DEPTH);
   localparam int CNT_W     = $clog2(POOL_DEPTH + 1);
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int PROD_W    = IDX_W + SIZE_W;
   localparam int RESET_CAP = (POOL_DEPTH < int'(CAP_RESET)) ? POOL_DEPTH : int'(CAP_RESET);

   // configuration
   logic [ADDR_W-1:0] base_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [CAP_W-1:0]  cap_ff;

   // accepted item
   func_type          func_ff;
   logic [ADDR_W-1:0] addr_ff;

   // stack state
   logic [IDX_W-1:0]  stack_mem [POOL_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  rd_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic              orig_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              push_en;

   // staged result
   logic [ADDR_W-1:0]     stg_addr_ff, stg_addr_in;
   logic [SLOT_IDX_W-1:0] stg_idx_ff, stg_idx_in;
   status_type            stg_status_ff, stg_status_in;

   // output register
   logic                  rsp_valid_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   logic [SLOT_IDX_W-1:0] rsp_idx_ff;
   status_type            rsp_status_ff;
   logic [FREE_W-1:0]     rsp_free_ff;

   // divider
   logic              div_done;
   logic [ADDR_W-1:0] quotient;
   logic [SIZE_W-1:0] remainder;

   logic [SIZE_W-1:0] size_eff;
   logic [CMP_W-1:0]  cap_wide;
   logic [CNT_W-1:0]  cap_eff;
   logic [CNT_W-1:0]  top_pos;
   logic [IDX_W-1:0]  idx_sel;
   logic              below;

   // effective element size and capacity
   always_comb begin
      size_eff = (size_ff == '0) ? SIZE_W'(1) : size_ff;
      cap_wide = CMP_W'(cap_ff);
      if (cap_wide > CMP_W'(POOL_DEPTH)) begin
         cap_eff = CNT_W'(POOL_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_wide);
      end
      top_pos = count_ff - 1'b1;
      idx_sel = orig_ff ? pos_ff[IDX_W-1:0] : rd_ff;
      below   = addr_ff < base_ff;
   end

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         size_ff <= SIZE_RESET;
         cap_ff  <= CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE_ADDRESS:  base_ff <= csr_data;
            CSR_SLOT_SIZE:     size_ff <= csr_data[SIZE_W-1:0];
            CSR_POOL_CAPACITY: cap_ff  <= csr_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= func_type'(req_func);
         addr_ff <= req_freed_address;
      end
   end

   // offset division for release checks
   flsa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (addr_ff - base_ff),
      .divisor   (size_eff),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // next stack state and staged result
   always_comb begin
      count_in      = count_ff;
      lo_in         = lo_ff;
      push_en       = 1'b0;
      stg_addr_in   = stg_addr_ff;
      stg_idx_in    = stg_idx_ff;
      stg_status_in = stg_status_ff;
      if (cmd.refill || cmd.set_nop || cmd.set_empty) begin
         stg_addr_in   = '0;
         stg_idx_in    = '0;
         stg_status_in = cmd.set_empty ? ST_EMPTY : ST_OK;
         if (cmd.refill) begin
            count_in = cap_eff;
            lo_in    = cap_eff;
         end
      end else if (cmd.acq_commit) begin
         count_in      = top_pos;
         lo_in         = orig_ff ? pos_ff : lo_ff;
         stg_addr_in   = base_ff + ADDR_W'(prod_ff);
         stg_idx_in    = SLOT_IDX_W'(idx_ff);
         stg_status_in = ST_OK;
      end else if (cmd.rel_commit) begin
         stg_addr_in = '0;
         stg_idx_in  = '0;
         if (below) begin
            stg_status_in = ST_BELOW;
         end else if (remainder != '0) begin
            stg_status_in = ST_MISALIGN;
         end else if (quotient >= ADDR_W'(cap_eff)) begin
            stg_status_in = ST_RANGE;
         end else if (count_ff >= cap_eff) begin
            stg_status_in = ST_FULL;
         end else begin
            stg_status_in = ST_OK;
            stg_idx_in    = SLOT_IDX_W'(quotient[IDX_W-1:0]);
            count_in      = count_ff + 1'b1;
            push_en       = 1'b1;
         end
      end
   end

   // stack count and low-water mark: entries below the mark still hold
   // their refill value, so their memory contents are never used
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(RESET_CAP);
         lo_ff    <= CNT_W'(RESET_CAP);
      end else begin
         count_ff <= count_in;
         lo_ff    <= lo_in;
      end
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[count_ff[IDX_W-1:0]] <= quotient[IDX_W-1:0];
      end
      if (cmd.acq_read) begin
         rd_ff   <= stack_mem[top_pos[IDX_W-1:0]];
         pos_ff  <= top_pos;
         orig_ff <= top_pos < lo_ff;
      end
   end

   // index select and slot offset multiply
   always_ff @(posedge clock) begin
      if (cmd.acq_mul) begin
         idx_ff  <= idx_sel;
         prod_ff <= PROD_W'(idx_sel) * PROD_W'(size_eff);
      end
   end

   // staged result
   always_ff @(posedge clock) begin
      stg_addr_ff   <= stg_addr_in;
      stg_idx_ff    <= stg_idx_in;
      stg_status_ff <= stg_status_in;
   end

   // output register: hold while stalled, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_addr_ff   <= stg_addr_ff;
         rsp_idx_ff    <= stg_idx_ff;
         rsp_status_ff <= stg_status_ff;
         rsp_free_ff   <= FREE_W'(count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_slot_index   = rsp_idx_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_free_slots   = rsp_free_ff;

   // status to the controller
   always_comb begin
      stat.func       = func_ff;
      stat.count_zero = (count_ff == '0);
      stat.div_done   = div_done;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule : flsa_datapath
`default_nettype wire

// ----- rtl/flsa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flsa_ctrl
// Controller state machine: takes one item at a time, steps the datapath
// through acquire, release, refill or no-op and hands the result to the
// output register.
// ----------------------------------------------------------------------------
module flsa_ctrl
   import flsa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output flsa_cmd_type       cmd,
   input  wire flsa_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ACQ_MUL,
      S_ACQ_ADD,
      S_REL_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.func)
               FUNC_ACQUIRE: begin
                  if (stat.count_zero) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_FINISH;
                  end else begin
                     cmd.acq_read = 1'b1;
                     state_in     = S_ACQ_MUL;
                  end
               end
               FUNC_RELEASE: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_REL_WAIT;
               end
               FUNC_RESET_POOL: begin
                  cmd.refill = 1'b1;
                  state_in   = S_FINISH;
               end
               FUNC_NOP: begin
                  cmd.set_nop = 1'b1;
                  state_in    = S_FINISH;
               end
            endcase
         end
         S_ACQ_MUL: begin
            cmd.acq_mul = 1'b1;
            state_in    = S_ACQ_ADD;
         end
         S_ACQ_ADD: begin
            cmd.acq_commit = 1'b1;
            state_in       = S_FINISH;
         end
         S_REL_WAIT: begin
            if (stat.div_done) begin
               cmd.rel_commit = 1'b1;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule : flsa_ctrl
`default_nettype wire

// ----- rtl/free_list_slot_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// free_list_slot_allocator_unit
// Fixed-block pool allocator over a LIFO stack of free slot indices.
// ----------------------------------------------------------------------------
// The unit handles one item at a time and answers each with exactly one
// result. An acquire steps through a stack memory read, an index multiply
// and an add, and skips them on an empty pool; a release waits for the
// 32-step restoring divider that forms the offset divided by the slot size
// and its remainder; reset pool and the unused code go straight to the
// result. A finished result waits in the output register, so the next item
// is accepted while it is stalled. The stack memory needs no clearing pass:
// a low-water mark marks the entries that still hold their refill value, so
// reset and reset pool complete at once. Configuration writes are always
// ready and must only be issued while the unit is idle.
module free_list_slot_allocator_unit
   import flsa_pkg::*;
#(
   parameter int POOL_DEPTH = 1024
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [ADDR_W-1:0]    req_freed_address,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ADDR_W-1:0]         rsp_slot_address,
   output logic [SLOT_IDX_W-1:0]     rsp_slot_index,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [FREE_W-1:0]         rsp_free_slots,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data
);

   flsa_cmd_type  cmd;
   flsa_stat_type stat;

   // sequencing
   flsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage and arithmetic
   flsa_datapath #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_freed_address (req_freed_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_address  (rsp_slot_address),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_status        (rsp_status),
      .rsp_free_slots    (rsp_free_slots),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

endmodule : free_list_slot_allocator_unit
`default_nettype wire

// ----- dv/tb_free_list_slot_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_list_slot_allocator_unit
// Self-checking testbench for the free-list slot allocator. A shadow copy of
// the free stack, its count and the three registers predicts the result of
// every accepted item. Each returned result is checked field by field against
// the oldest prediction. Directed tests cover the reset pool, register
// extremes, zero size and out-of-range capacity. A long random phase follows,
// with mostly well-formed releases and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_free_list_slot_allocator_unit
   import flsa_pkg::*;
();

   localparam int POOL_DEPTH   = 1024;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_IDLE     = 11;
   localparam int PHASE_ITEMS  = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ADDR_W-1:0]     slot_address;
      logic [SLOT_IDX_W-1:0] slot_index;
      status_type            status;
      logic [FREE_W-1:0]     free_slots;
   } slot_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func = FUNC_NOP;
   logic [ADDR_W-1:0]     req_freed_address = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ADDR_W-1:0]     rsp_slot_address;
   logic [SLOT_IDX_W-1:0] rsp_slot_index;
   logic [STATUS_W-1:0]   rsp_status;
   logic [FREE_W-1:0]     rsp_free_slots;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [ADDR_W-1:0]     csr_data = '0;

   // shadow registers and free stack
   logic [ADDR_W-1:0]     base_q;
   logic [SIZE_W-1:0]     size_q;
   logic [CAP_W-1:0]      cap_q;
   logic [SLOT_IDX_W-1:0] shadow_stack [POOL_DEPTH];
   logic [FREE_W-1:0]     free_total;

   slot_outcome_type pending_outcomes [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               rsp_hold = 0;
   bit               quiet = 1'b0;

   free_list_slot_allocator_unit #(
      .POOL_DEPTH(POOL_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_freed_address (req_freed_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_address  (rsp_slot_address),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_status        (rsp_status),
      .rsp_free_slots    (rsp_free_slots),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // zero size counts as one byte per slot
   function automatic logic [ADDR_W-1:0] slot_size();
      return (size_q == '0) ? 32'd1 : {16'd0, size_q};
   endfunction

   // clamp capacity to the stack depth
   function automatic logic [CAP_W-1:0] slot_capacity();
      return (cap_q > POOL_DEPTH) ? CAP_W'(POOL_DEPTH) : cap_q;
   endfunction

   // refill with 0 .. capacity-1, capacity-1 on top
   function automatic void refill_shadow_stack();
      for (int i = 0; i < slot_capacity(); i++)
         shadow_stack[i] = SLOT_IDX_W'(i);
      free_total = slot_capacity();
   endfunction

   // advance the shadow pool by one item and return its result
   function automatic slot_outcome_type pool_outcome(input func_type op,
                                                     input logic [ADDR_W-1:0] addr);
      slot_outcome_type  o;
      logic [ADDR_W-1:0] es;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] idx;
      logic [CAP_W-1:0]  cap;
      o      = '0;
      es     = slot_size();
      cap    = slot_capacity();
      offset = '0;
      idx    = '0;
      case (op)
         FUNC_ACQUIRE: begin
            if (free_total == 0 || free_total > POOL_DEPTH) begin
               o.status = ST_EMPTY;
            end else begin
               free_total--;
               o.slot_index   = shadow_stack[free_total];
               o.slot_address = base_q + ADDR_W'(o.slot_index) * es;
            end
         end
         FUNC_RELEASE: begin
            if (addr < base_q) begin
               o.status = ST_BELOW;
            end else begin
               offset = addr - base_q;
               idx    = offset / es;
               if (offset % es != 0)
                  o.status = ST_MISALIGN;
               else if (idx >= cap)
                  o.status = ST_RANGE;
               else if (free_total >= cap || free_total >= POOL_DEPTH)
                  o.status = ST_FULL;
               else begin
                  shadow_stack[free_total] = idx[SLOT_IDX_W-1:0];
                  free_total++;
                  o.slot_index = idx[SLOT_IDX_W-1:0];
               end
            end
         end
         FUNC_RESET_POOL: refill_shadow_stack();
         default: ;
      endcase
      o.free_slots = free_total;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      error_count++;
   endtask

   // send one item after a random gap and record its predicted result
   task automatic send_item(input func_type op, input logic [ADDR_W-1:0] addr);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= op;
      req_freed_address <= addr;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(pool_outcome(op, addr));
   endtask

   // hold the sender until every result is back and the unit is idle
   task automatic wait_pool_idle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BASE_ADDRESS:  base_q = data;
         CSR_SLOT_SIZE:     size_q = data[SIZE_W-1:0];
         CSR_POOL_CAPACITY: cap_q  = data[CAP_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_pool(input logic [ADDR_W-1:0] base,
                                 input logic [ADDR_W-1:0] size,
                                 input logic [ADDR_W-1:0] cap);
      wait_pool_idle();
      write_reg(CSR_BASE_ADDRESS, base);
      write_reg(CSR_SLOT_SIZE, size);
      write_reg(CSR_POOL_CAPACITY, cap);
   endtask

   // check each accepted result against the oldest prediction; draw stalls
   always @(posedge clock) begin
      slot_outcome_type want;
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("result with no item pending, status %0d",
                                         rsp_status));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_slot_address !== want.slot_address)
                  report_mismatch($sformatf("slot_address got 0x%08h expected 0x%08h",
                                            rsp_slot_address, want.slot_address));
               if (rsp_slot_index !== want.slot_index)
                  report_mismatch($sformatf("slot_index got %0d expected %0d",
                                            rsp_slot_index, want.slot_index));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, want.status));
               if (rsp_free_slots !== want.free_slots)
                  report_mismatch($sformatf("free_slots got %0d expected %0d",
                                            rsp_free_slots, want.free_slots));
            end
            rsp_hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // reset registers: pop from the top, fill to full, overflow, out of range
   task automatic test_default_pool();
      send_item(FUNC_ACQUIRE, 32'hFFFF_FFFF);
      send_item(FUNC_ACQUIRE, 32'h0);
      send_item(FUNC_RELEASE, 32'd1023);
      send_item(FUNC_RELEASE, 32'd1022);
      send_item(FUNC_RELEASE, 32'd0);
      send_item(FUNC_RELEASE, 32'd1024);
      send_item(FUNC_NOP, 32'hFFFF_FFFF);
      send_item(FUNC_RESET_POOL, 32'h5555_AAAA);
      send_item(FUNC_ACQUIRE, 32'h0);
   endtask

   // top base and size: wrapped addresses, empty, below, misaligned, full
   task automatic test_register_extremes();
      configure_pool(32'hFFFF_FFF0, 32'h0000_FFFF, 32'd2);
      send_item(FUNC_RESET_POOL, 32'h0);
      send_item(FUNC_ACQUIRE, 32'h0);
      send_item(FUNC_ACQUIRE, 32'h0);
      send_item(FUNC_ACQUIRE, 32'h0);
      send_item(FUNC_RELEASE, 32'h0000_0000);
      send_item(FUNC_RELEASE, 32'hFFFF_FFF1);
      send_item(FUNC_RELEASE, 32'hFFFF_FFF0);
      send_item(FUNC_RELEASE, 32'hFFFF_FFF0);
      send_item(FUNC_RELEASE, 32'hFFFF_FFF0);
      send_item(FUNC_RELEASE, 32'hFFFF_FFFF);
   endtask

   // zero size, zero and oversized capacity, capacity changed without refill
   task automatic test_degenerate_registers();
      configure_pool(32'h100, 32'h0, 32'h0);
      write_reg(CSR_UNUSED, $urandom);
      send_item(FUNC_RESET_POOL, 32'h0);
      send_item(FUNC_ACQUIRE, 32'h0);
      send_item(FUNC_RELEASE, 32'h100);
      configure_pool(32'h100, 32'h0, 32'd2047);
      send_item(FUNC_RESET_POOL, 32'h0);
      send_item(FUNC_RELEASE, 32'h100 + 32'd1023);
      send_item(FUNC_ACQUIRE, 32'h0);
      send_item(FUNC_RELEASE, 32'h100 + 32'd1024);
      configure_pool(32'h100, 32'h0, 32'd4);
      send_item(FUNC_RELEASE, 32'h102);
      send_item(FUNC_ACQUIRE, 32'h0);
   endtask

   // random phases over several register settings, mostly valid releases
   task automatic test_random_traffic();
      int                quiet_start;
      int                pick;
      int                sel;
      func_type          op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] es;
      logic [ADDR_W-1:0] cap;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: configure_pool($urandom, $urandom_range(1, 64), $urandom_range(1, 16));
            1: configure_pool(32'h0, 32'd1, 32'd1024);
            2: configure_pool(32'hFFFF_FFFF - $urandom_range(0, 4096), 32'hFFFF,
                              $urandom_range(1, 8));
            3: configure_pool($urandom, $urandom_range(1, 65535), $urandom_range(1, 32));
            default: configure_pool($urandom_range(0, 255), 32'h0, 32'd2047);
         endcase
         if ($urandom_range(0, 1))
            send_item(FUNC_RESET_POOL, $urandom);
         quiet_start = $urandom_range(0, PHASE_ITEMS - 50);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            quiet = (i >= quiet_start) && (i < quiet_start + 30);
            pick  = $urandom_range(0, 99);
            addr  = $urandom;
            if (pick < 45) begin
               op = FUNC_ACQUIRE;
            end else if (pick < 90) begin
               op  = FUNC_RELEASE;
               es  = slot_size();
               cap = ADDR_W'(slot_capacity());
               sel = $urandom_range(0, 99);
               // well-formed slot address, just past the end, misaligned, below
               if (sel < 70)
                  addr = base_q + $urandom_range(0, cap - 1) * es;
               else if (sel < 80)
                  addr = base_q + (cap + $urandom_range(0, 3)) * es;
               else if (sel < 90)
                  addr = base_q + $urandom_range(0, cap) * es +
                         $urandom_range(1, (es > 1) ? es - 1 : 1);
               else if (sel < 95 && base_q != 0)
                  addr = $urandom_range(0, base_q - 1);
            end else if (pick < 95) begin
               op = FUNC_RESET_POOL;
            end else begin
               op = FUNC_NOP;
            end
            send_item(op, addr);
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      base_q = BASE_RESET;
      size_q = SIZE_RESET;
      cap_q  = CAP_RESET;
      refill_shadow_stack();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_pool();
      test_register_extremes();
      test_degenerate_registers();
      test_random_traffic();
      wait_pool_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule : tb_free_list_slot_allocator_unit
